FILE: rtl/core/tddm_pkg.sv
// ----------------------------------------------------------------------------
// tddm_pkg
// Shared types, constants and the arctangent table of the tilt deadband
// display mapper.
// ----------------------------------------------------------------------------
package tddm_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = $clog2(TAB_LEN);

  localparam int IN_W   = 16;
  localparam int FRAC_W = 16;
  localparam int CW     = 36;
  localparam int ZW     = 24;
  localparam int ANG_W  = 16;

  localparam int RAD_W      = 32;
  localparam int REM_W      = RAD_W + 2;
  localparam int ROOT_ITERS = RAD_W;
  localparam int CNT_W      = $clog2(ROOT_ITERS);

  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int ROLL_W  = 15;
  localparam int PITCH_W = 14;

  localparam logic signed [ZW-1:0]    DEG90     = 24'sd1474560;
  localparam int                      Z_ROUND   = 128;
  localparam int                      Z_SHIFT   = 8;
  localparam logic signed [ANG_W-1:0] ANG_180   = 16'sd11520;
  localparam logic signed [ANG_W-1:0] ANG_90    = 16'sd5760;
  localparam logic signed [ANG_W-1:0] ROLL_LIM  = 16'sd11520;
  localparam logic signed [ANG_W-1:0] PITCH_LIM = 16'sd5760;

  localparam int PITCH_REF  = 55;
  localparam int PITCH_TOP  = 43;
  localparam int BAR_SHIFT  = 15;
  localparam int GAIN_SHIFT = 14;
  localparam int SQ_LAST    = 2;

  localparam int NUM_REGS = 5;
  localparam int PADDR_W  = $clog2(NUM_REGS * 4);
  localparam int PDATA_W  = 32;

  localparam int GDB_W  = 16;
  localparam int TDB_W  = 14;
  localparam int GAIN_W = 10;
  localparam int BHW_W  = 7;

  localparam logic [GDB_W-1:0]  GDB_RST  = 16'd100;
  localparam logic [TDB_W-1:0]  TDB_RST  = 14'd64;
  localparam logic [GAIN_W-1:0] GAIN_RST = 10'd205;
  localparam logic [BHW_W-1:0]  BHW_RST  = 7'd54;

  typedef enum logic [PADDR_W-3:0] {
    REG_GYRO_DB    = 3'd0,
    REG_TILT_DB    = 3'd1,
    REG_ROLL_GAIN  = 3'd2,
    REG_PITCH_GAIN = 3'd3,
    REG_BAR_HALF   = 3'd4
  } reg_idx_t;

  localparam int NUM_MAP = 5;

  typedef enum logic [2:0] {
    MAP_GX    = 3'd0,
    MAP_GY    = 3'd1,
    MAP_GZ    = 3'd2,
    MAP_ROLL  = 3'd3,
    MAP_PITCH = 3'd4
  } map_item_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQUARE = 8'b0000_0010,
    S_ROOT   = 8'b0000_0100,
    S_CSETUP = 8'b0000_1000,
    S_CITER  = 8'b0001_0000,
    S_DECIDE = 8'b0010_0000,
    S_MAP    = 8'b0100_0000,
    S_PUSH   = 8'b1000_0000
  } state_t;

  // atan(2^-i) in 1/16384 degree, rounded.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 24'sd737280;
      5'd1:    v = 24'sd435242;
      5'd2:    v = 24'sd229970;
      5'd3:    v = 24'sd116736;
      5'd4:    v = 24'sd58595;
      5'd5:    v = 24'sd29326;
      5'd6:    v = 24'sd14667;
      5'd7:    v = 24'sd7334;
      5'd8:    v = 24'sd3667;
      5'd9:    v = 24'sd1833;
      5'd10:   v = 24'sd917;
      5'd11:   v = 24'sd458;
      5'd12:   v = 24'sd229;
      5'd13:   v = 24'sd115;
      5'd14:   v = 24'sd57;
      5'd15:   v = 24'sd29;
      5'd16:   v = 24'sd14;
      5'd17:   v = 24'sd7;
      5'd18:   v = 24'sd4;
      5'd19:   v = 24'sd2;
      5'd20:   v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/tddm_if.sv
// ----------------------------------------------------------------------------
// tddm channel interfaces
// Valid/ready channels for the IMU sample words and the display result words.
// ----------------------------------------------------------------------------
interface tddm_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [tddm_pkg::IN_W-1:0]    accel_x;
  logic signed [tddm_pkg::IN_W-1:0]    accel_y;
  logic signed [tddm_pkg::IN_W-1:0]    accel_z;
  logic signed [tddm_pkg::IN_W-1:0]    gyro_x;
  logic signed [tddm_pkg::IN_W-1:0]    gyro_y;
  logic signed [tddm_pkg::IN_W-1:0]    gyro_z;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface

interface tddm_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 update;
  logic [tddm_pkg::COL_W-1:0]           bar_end_x;
  logic [tddm_pkg::COL_W-1:0]           bar_end_y;
  logic [tddm_pkg::COL_W-1:0]           bar_end_z;
  logic [tddm_pkg::COL_W-1:0]           roll_marker_col;
  logic [tddm_pkg::ROW_W-1:0]           pitch_marker_row;
  logic signed [tddm_pkg::ROLL_W-1:0]   roll_angle;
  logic signed [tddm_pkg::PITCH_W-1:0]  pitch_angle;

  modport source (output valid, update, bar_end_x, bar_end_y, bar_end_z, roll_marker_col,
                  pitch_marker_row, roll_angle, pitch_angle, input ready);
  modport sink (input valid, update, bar_end_x, bar_end_y, bar_end_z, roll_marker_col,
                pitch_marker_row, roll_angle, pitch_angle, output ready);
endinterface

FILE: rtl/core/tilt_deadband_display_mapper_unit.sv
// ----------------------------------------------------------------------------
// tilt_deadband_display_mapper_unit
// Computes roll and pitch from one accelerometer sample with a shared CORDIC
// unit, applies gyro and tilt deadbands against the stored values and maps
// the stored values to display bar ends and marker positions.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Word
//  sample    in   valid / ready          accel_x/y/z, gyro_x/y/z
//  result    out  valid / ready          update, bars, markers, angles
//  apb       in   psel, penable, pwrite  five configuration registers
//
//  A sample passes through squaring, square root, two CORDIC passes,
//  deadband compare, mapping, result load and idle. A CORDIC pass on an
//  axis ends at its setup step. The single 17x17 multiplier and
//  the CORDIC add/shift unit are used in turn. Reset is synchronous; it
//  restores register defaults and clears the stored values. A finished word
//  waits in the result register while the next sample is taken; the unit
//  holds at its load step if that word has still not been taken.
// ----------------------------------------------------------------------------
module tilt_deadband_display_mapper_unit (
  input  logic                             clk,
  input  logic                             rst,
  tddm_sample_if.sink                      sample,
  tddm_result_if.source                    result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tddm_pkg::PADDR_W-1:0]     paddr,
  input  logic [tddm_pkg::PDATA_W-1:0]     pwdata,
  output logic [tddm_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  tddm_pkg::state_t state;
  logic [tddm_pkg::CNT_W-1:0] cnt;
  logic pass;

  logic [tddm_pkg::GDB_W-1:0]  gyro_deadband;
  logic [tddm_pkg::TDB_W-1:0]  tilt_deadband;
  logic [tddm_pkg::GAIN_W-1:0] roll_gain;
  logic [tddm_pkg::GAIN_W-1:0] pitch_gain;
  logic [tddm_pkg::BHW_W-1:0]  bar_half_width;

  logic signed [tddm_pkg::IN_W-1:0]    ax, ay, az, gx, gy, gz;
  logic signed [tddm_pkg::IN_W-1:0]    prev_gyro_x, prev_gyro_y, prev_gyro_z;
  logic signed [tddm_pkg::ROLL_W-1:0]  prev_roll, roll_new;
  logic signed [tddm_pkg::PITCH_W-1:0] prev_pitch, pitch_new;

  logic [tddm_pkg::RAD_W-1:0] radicand, root, root_next;
  logic [tddm_pkg::REM_W-1:0] rem, rem_next;
  logic [tddm_pkg::REM_W+1:0] rem_sh, trial;

  logic signed [tddm_pkg::CW-1:0] cx, cy, cx_next, cy_next, x0, y0, rx0, ry0, dx, dy;
  logic signed [tddm_pkg::ZW-1:0] cz, cz_next, rz0, tab;
  logic cord_special, cord_last;
  logic signed [tddm_pkg::ANG_W-1:0] ang_val, ang_lim, ang_clamped;
  logic ang_we;

  logic signed [tddm_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [tddm_pkg::PROD_W-1:0] prod;

  logic upd, upd_flag;
  tddm_pkg::map_item_t map_idx;
  logic [tddm_pkg::COL_W-1:0] map_res [tddm_pkg::NUM_MAP];
  logic push_go;

  logic res_valid, out_update;
  logic [tddm_pkg::COL_W-1:0] out_bar_x, out_bar_y, out_bar_z, out_col;
  logic [tddm_pkg::ROW_W-1:0] out_row;
  logic signed [tddm_pkg::ROLL_W-1:0]  out_roll;
  logic signed [tddm_pkg::PITCH_W-1:0] out_pitch;

  function automatic logic signed [tddm_pkg::CW-1:0] scale_in(
    input logic signed [tddm_pkg::IN_W-1:0] a
  );
    return {{(tddm_pkg::CW-tddm_pkg::IN_W-tddm_pkg::FRAC_W){a[tddm_pkg::IN_W-1]}},
            a, {tddm_pkg::FRAC_W{1'b0}}};
  endfunction

  function automatic logic beyond(input logic signed [16:0] a, input logic signed [16:0] b,
                                  input logic [tddm_pkg::GDB_W-1:0] db);
    logic signed [17:0] d;
    d = 18'(a) - 18'(b);
    if (d < 0) begin
      d = -d;
    end
    return d > $signed({2'b00, db});
  endfunction

  function automatic logic [tddm_pkg::COL_W-1:0] map_pos(
    input logic signed [tddm_pkg::PROD_W-1:0] p,
    input tddm_pkg::map_item_t k
  );
    logic signed [tddm_pkg::PROD_W-1:0] bias, q, v, ctr, lo, hi;
    logic [3:0] sh;
    if (k == tddm_pkg::MAP_ROLL || k == tddm_pkg::MAP_PITCH) begin
      sh = 4'(tddm_pkg::GAIN_SHIFT);
    end else begin
      sh = 4'(tddm_pkg::BAR_SHIFT);
    end
    if (p < 0) begin
      bias = (tddm_pkg::PROD_W'(1) <<< sh) - tddm_pkg::PROD_W'(1);
    end else begin
      bias = '0;
    end
    q = (p + bias) >>> sh;
    if (k == tddm_pkg::MAP_PITCH) begin
      ctr = tddm_pkg::PROD_W'(tddm_pkg::PITCH_REF);
      lo  = tddm_pkg::PROD_W'(tddm_pkg::PITCH_TOP);
      hi  = tddm_pkg::PROD_W'(tddm_pkg::SCREEN_HEIGHT - 1);
    end else begin
      ctr = tddm_pkg::PROD_W'(tddm_pkg::SCREEN_WIDTH / 2);
      lo  = '0;
      hi  = tddm_pkg::PROD_W'(tddm_pkg::SCREEN_WIDTH - 1);
    end
    v = ctr + q;
    if (v < lo) begin
      v = lo;
    end else if (v > hi) begin
      v = hi;
    end
    return v[tddm_pkg::COL_W-1:0];
  endfunction

  function automatic logic signed [tddm_pkg::ANG_W-1:0] z_to_ang(
    input logic signed [tddm_pkg::ZW-1:0] z
  );
    logic signed [tddm_pkg::ZW-1:0] t;
    t = (z + tddm_pkg::ZW'(tddm_pkg::Z_ROUND)) >>> tddm_pkg::Z_SHIFT;
    return t[tddm_pkg::ANG_W-1:0];
  endfunction

  assign sample.ready = (state == tddm_pkg::S_IDLE);
  assign pready = 1'b1;
  assign push_go = !res_valid || result.ready;

  always_comb begin
    prdata = '0;
    case (paddr[tddm_pkg::PADDR_W-1:2])
      tddm_pkg::REG_GYRO_DB:    prdata = tddm_pkg::PDATA_W'(gyro_deadband);
      tddm_pkg::REG_TILT_DB:    prdata = tddm_pkg::PDATA_W'(tilt_deadband);
      tddm_pkg::REG_ROLL_GAIN:  prdata = tddm_pkg::PDATA_W'(roll_gain);
      tddm_pkg::REG_PITCH_GAIN: prdata = tddm_pkg::PDATA_W'(pitch_gain);
      tddm_pkg::REG_BAR_HALF:   prdata = tddm_pkg::PDATA_W'(bar_half_width);
      default:                  prdata = '0;
    endcase
  end

  // Square root, two radicand bits per step.
  always_comb begin
    rem_sh = {rem, radicand[tddm_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = tddm_pkg::REM_W'(rem_sh - trial);
      root_next = {root[tddm_pkg::RAD_W-2:0], 1'b1};
    end else begin
      rem_next  = tddm_pkg::REM_W'(rem_sh);
      root_next = {root[tddm_pkg::RAD_W-2:0], 1'b0};
    end
  end

  // CORDIC setup, special cases and one vectoring step.
  always_comb begin
    if (pass) begin
      x0 = {{(tddm_pkg::CW-tddm_pkg::RAD_W){1'b0}}, root};
      y0 = -scale_in(ax);
    end else begin
      x0 = scale_in(az);
      y0 = scale_in(ay);
    end
    cord_special = (y0 == 0) || (x0 == 0);
    if (x0 < 0) begin
      if (y0 > 0) begin
        rx0 = y0;
        ry0 = -x0;
        rz0 = tddm_pkg::DEG90;
      end else begin
        rx0 = -y0;
        ry0 = x0;
        rz0 = -tddm_pkg::DEG90;
      end
    end else begin
      rx0 = x0;
      ry0 = y0;
      rz0 = '0;
    end

    dx  = cy >>> cnt;
    dy  = cx >>> cnt;
    tab = tddm_pkg::atan_entry(tddm_pkg::TAB_IDX_W'(cnt));
    if (!cy[tddm_pkg::CW-1]) begin
      cx_next = cx + dx;
      cy_next = cy - dy;
      cz_next = cz + tab;
    end else begin
      cx_next = cx - dx;
      cy_next = cy + dy;
      cz_next = cz - tab;
    end
    cord_last = (cnt == tddm_pkg::CNT_W'(tddm_pkg::CORDIC_STEPS - 1));

    if (state == tddm_pkg::S_CSETUP) begin
      if (y0 == 0) begin
        ang_val = x0[tddm_pkg::CW-1] ? tddm_pkg::ANG_180 : '0;
      end else begin
        ang_val = (y0 > 0) ? tddm_pkg::ANG_90 : -tddm_pkg::ANG_90;
      end
    end else begin
      ang_val = z_to_ang(cz_next);
    end
    ang_we = ((state == tddm_pkg::S_CSETUP) && cord_special) ||
             ((state == tddm_pkg::S_CITER) && cord_last);
    ang_lim = pass ? tddm_pkg::PITCH_LIM : tddm_pkg::ROLL_LIM;
    if (ang_val > ang_lim) begin
      ang_clamped = ang_lim;
    end else if (ang_val < -ang_lim) begin
      ang_clamped = -ang_lim;
    end else begin
      ang_clamped = ang_val;
    end
  end

  always_comb begin
    upd = beyond(17'(gx), 17'(prev_gyro_x), gyro_deadband) ||
          beyond(17'(gy), 17'(prev_gyro_y), gyro_deadband) ||
          beyond(17'(gz), 17'(prev_gyro_z), gyro_deadband) ||
          beyond(17'(roll_new), 17'(prev_roll), tddm_pkg::GDB_W'(tilt_deadband)) ||
          beyond(17'(pitch_new), 17'(prev_pitch), tddm_pkg::GDB_W'(tilt_deadband));
  end

  always_comb begin
    map_idx = tddm_pkg::map_item_t'(cnt[2:0] - 3'd1);
    mul_a = '0;
    mul_b = '0;
    case (state)
      tddm_pkg::S_SQUARE: begin
        if (cnt == '0) begin
          mul_a = tddm_pkg::MUL_W'(ay);
          mul_b = tddm_pkg::MUL_W'(ay);
        end else begin
          mul_a = tddm_pkg::MUL_W'(az);
          mul_b = tddm_pkg::MUL_W'(az);
        end
      end
      tddm_pkg::S_MAP: begin
        case (tddm_pkg::map_item_t'(cnt[2:0]))
          tddm_pkg::MAP_GX: begin
            mul_a = tddm_pkg::MUL_W'(prev_gyro_x);
            mul_b = tddm_pkg::MUL_W'(bar_half_width);
          end
          tddm_pkg::MAP_GY: begin
            mul_a = tddm_pkg::MUL_W'(prev_gyro_y);
            mul_b = tddm_pkg::MUL_W'(bar_half_width);
          end
          tddm_pkg::MAP_GZ: begin
            mul_a = tddm_pkg::MUL_W'(prev_gyro_z);
            mul_b = tddm_pkg::MUL_W'(bar_half_width);
          end
          tddm_pkg::MAP_ROLL: begin
            mul_a = tddm_pkg::MUL_W'(prev_roll);
            mul_b = tddm_pkg::MUL_W'(roll_gain);
          end
          tddm_pkg::MAP_PITCH: begin
            mul_a = tddm_pkg::MUL_W'(prev_pitch);
            mul_b = tddm_pkg::MUL_W'(pitch_gain);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tddm_pkg::S_IDLE;
      cnt            <= '0;
      pass           <= 1'b0;
      res_valid      <= 1'b0;
      gyro_deadband  <= tddm_pkg::GDB_RST;
      tilt_deadband  <= tddm_pkg::TDB_RST;
      roll_gain      <= tddm_pkg::GAIN_RST;
      pitch_gain     <= tddm_pkg::GAIN_RST;
      bar_half_width <= tddm_pkg::BHW_RST;
      prev_gyro_x    <= '0;
      prev_gyro_y    <= '0;
      prev_gyro_z    <= '0;
      prev_roll      <= '0;
      prev_pitch     <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[tddm_pkg::PADDR_W-1:2])
          tddm_pkg::REG_GYRO_DB:    gyro_deadband  <= pwdata[tddm_pkg::GDB_W-1:0];
          tddm_pkg::REG_TILT_DB:    tilt_deadband  <= pwdata[tddm_pkg::TDB_W-1:0];
          tddm_pkg::REG_ROLL_GAIN:  roll_gain      <= pwdata[tddm_pkg::GAIN_W-1:0];
          tddm_pkg::REG_PITCH_GAIN: pitch_gain     <= pwdata[tddm_pkg::GAIN_W-1:0];
          tddm_pkg::REG_BAR_HALF:   bar_half_width <= pwdata[tddm_pkg::BHW_W-1:0];
          default: ;
        endcase
      end

      if (res_valid && result.ready && state != tddm_pkg::S_PUSH) begin
        res_valid <= 1'b0;
      end

      case (state)
        tddm_pkg::S_IDLE: begin
          if (sample.valid) begin
            state <= tddm_pkg::S_SQUARE;
            cnt   <= '0;
          end
        end
        tddm_pkg::S_SQUARE: begin
          if (cnt == tddm_pkg::CNT_W'(tddm_pkg::SQ_LAST)) begin
            state <= tddm_pkg::S_ROOT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        tddm_pkg::S_ROOT: begin
          if (cnt == tddm_pkg::CNT_W'(tddm_pkg::ROOT_ITERS - 1)) begin
            state <= tddm_pkg::S_CSETUP;
            cnt   <= '0;
            pass  <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        tddm_pkg::S_CSETUP: begin
          cnt <= '0;
          if (cord_special) begin
            if (pass) begin
              state <= tddm_pkg::S_DECIDE;
            end else begin
              pass <= 1'b1;
            end
          end else begin
            state <= tddm_pkg::S_CITER;
          end
        end
        tddm_pkg::S_CITER: begin
          if (cord_last) begin
            cnt <= '0;
            if (pass) begin
              state <= tddm_pkg::S_DECIDE;
            end else begin
              pass  <= 1'b1;
              state <= tddm_pkg::S_CSETUP;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        tddm_pkg::S_DECIDE: begin
          if (upd) begin
            prev_gyro_x <= gx;
            prev_gyro_y <= gy;
            prev_gyro_z <= gz;
            prev_roll   <= roll_new;
            prev_pitch  <= pitch_new;
          end
          state <= tddm_pkg::S_MAP;
          cnt   <= '0;
        end
        tddm_pkg::S_MAP: begin
          if (cnt == tddm_pkg::CNT_W'(tddm_pkg::NUM_MAP)) begin
            state <= tddm_pkg::S_PUSH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        tddm_pkg::S_PUSH: begin
          if (push_go) begin
            res_valid <= 1'b1;
            state     <= tddm_pkg::S_IDLE;
          end
        end
        default: state <= tddm_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (sample.valid && sample.ready) begin
      ax <= sample.accel_x;
      ay <= sample.accel_y;
      az <= sample.accel_z;
      gx <= sample.gyro_x;
      gy <= sample.gyro_y;
      gz <= sample.gyro_z;
    end

    if (ang_we) begin
      if (pass) begin
        pitch_new <= ang_clamped[tddm_pkg::PITCH_W-1:0];
      end else begin
        roll_new <= ang_clamped[tddm_pkg::ROLL_W-1:0];
      end
    end

    case (state)
      tddm_pkg::S_SQUARE: begin
        if (cnt == tddm_pkg::CNT_W'(1)) begin
          radicand <= prod[tddm_pkg::RAD_W-1:0];
        end else if (cnt == tddm_pkg::CNT_W'(tddm_pkg::SQ_LAST)) begin
          radicand <= radicand + prod[tddm_pkg::RAD_W-1:0];
          rem      <= '0;
          root     <= '0;
        end
      end
      tddm_pkg::S_ROOT: begin
        rem      <= rem_next;
        root     <= root_next;
        radicand <= radicand << 2;
      end
      tddm_pkg::S_CSETUP: begin
        cx <= rx0;
        cy <= ry0;
        cz <= rz0;
      end
      tddm_pkg::S_CITER: begin
        cx <= cx_next;
        cy <= cy_next;
        cz <= cz_next;
      end
      tddm_pkg::S_DECIDE: begin
        upd_flag <= upd;
      end
      tddm_pkg::S_MAP: begin
        if (cnt != '0) begin
          map_res[map_idx] <= map_pos(prod, map_idx);
        end
      end
      tddm_pkg::S_PUSH: begin
        if (push_go) begin
          out_update <= upd_flag;
          out_bar_x  <= map_res[tddm_pkg::MAP_GX];
          out_bar_y  <= map_res[tddm_pkg::MAP_GY];
          out_bar_z  <= map_res[tddm_pkg::MAP_GZ];
          out_col    <= map_res[tddm_pkg::MAP_ROLL];
          out_row    <= map_res[tddm_pkg::MAP_PITCH][tddm_pkg::ROW_W-1:0];
          out_roll   <= prev_roll;
          out_pitch  <= prev_pitch;
        end
      end
      default: ;
    endcase
  end

  assign result.valid            = res_valid;
  assign result.update           = out_update;
  assign result.bar_end_x        = out_bar_x;
  assign result.bar_end_y        = out_bar_y;
  assign result.bar_end_z        = out_bar_z;
  assign result.roll_marker_col  = out_col;
  assign result.pitch_marker_row = out_row;
  assign result.roll_angle       = out_roll;
  assign result.pitch_angle      = out_pitch;

endmodule

FILE: sim/tb_tilt_deadband_display_mapper_unit.sv
// ----------------------------------------------------------------------------
// tb_tilt_deadband_display_mapper_unit
// Self-checking bench for the tilt deadband display mapper. A driver feeds
// IMU sample words from a backlog. A monitor takes result words with random
// stalls and checks every field against a bit-exact predictor. The predictor
// covers the CORDIC angles, the deadband decision, the stored state and the
// screen mapping. Several register settings are loaded over APB between
// phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_tilt_deadband_display_mapper_unit;

  localparam int SAMPLE_CYCLES = 78;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    logic signed [tddm_pkg::IN_W-1:0] ax, ay, az, gx, gy, gz;
  } imu_sample_t;

  typedef struct {
    logic                                update;
    logic [tddm_pkg::COL_W-1:0]          bar_x, bar_y, bar_z, col;
    logic [tddm_pkg::ROW_W-1:0]          row;
    logic signed [tddm_pkg::ROLL_W-1:0]  roll;
    logic signed [tddm_pkg::PITCH_W-1:0] pitch;
  } display_word_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [tddm_pkg::PADDR_W-1:0] paddr;
  logic [tddm_pkg::PDATA_W-1:0] pwdata, prdata;

  tddm_sample_if smp ();
  tddm_result_if res ();

  tilt_deadband_display_mapper_unit uut (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  longint atan_q14 [tddm_pkg::TAB_LEN] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  int gyro_db    = tddm_pkg::GDB_RST;
  int tilt_db    = tddm_pkg::TDB_RST;
  int roll_gain  = tddm_pkg::GAIN_RST;
  int pitch_gain = tddm_pkg::GAIN_RST;
  int bar_half   = tddm_pkg::BHW_RST;

  int held_gx, held_gy, held_gz, held_roll, held_pitch;

  imu_sample_t   sample_backlog[$];
  display_word_t due_words[$];
  imu_sample_t   cur_sample;
  imu_sample_t   last_sample;
  display_word_t want;

  int          samples_queued;
  int          words_checked;
  int          mismatches;
  int          send_gap;
  int          recv_stall;
  int unsigned cycle_count = 0;
  bit          calm;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit exceeds(int a, int b, int db);
    int d;
    d = a - b;
    if (d < 0) d = -d;
    return d > db;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Angle of (x, y) in 1/64 degree; the accumulator runs in 1/16384 degree.
  function automatic int tilt_atan2(longint xi, longint yi);
    longint x, y, z, dx, dy, t;
    x = xi;
    y = yi;
    z = 0;
    if (y == 0) return (x >= 0) ? 0 : int'(tddm_pkg::ANG_180);
    if (x == 0) return (y > 0) ? int'(tddm_pkg::ANG_90) : -int'(tddm_pkg::ANG_90);
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y;
        y = -t;
        z = longint'(tddm_pkg::DEG90);
      end else begin
        x = -y;
        y = t;
        z = -longint'(tddm_pkg::DEG90);
      end
    end
    for (int i = 0; i < tddm_pkg::CORDIC_STEPS && i < tddm_pkg::TAB_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q14[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q14[i];
      end
    end
    return int'((z + tddm_pkg::Z_ROUND) >>> tddm_pkg::Z_SHIFT);
  endfunction

  function automatic logic [tddm_pkg::COL_W-1:0] bar_column(int g);
    return tddm_pkg::COL_W'(clip(tddm_pkg::SCREEN_WIDTH / 2 +
                                 g * bar_half / (1 << tddm_pkg::BAR_SHIFT), 0,
                                 tddm_pkg::SCREEN_WIDTH - 1));
  endfunction

  function automatic display_word_t predict_display(imu_sample_t s);
    display_word_t w;
    longint unsigned sq;
    int roll, pitch;
    bit moved;
    roll = clip(tilt_atan2(longint'(s.az) * 65536, longint'(s.ay) * 65536),
                -int'(tddm_pkg::ROLL_LIM), int'(tddm_pkg::ROLL_LIM));
    sq = longint'(s.ay) * s.ay + longint'(s.az) * s.az;
    pitch = clip(tilt_atan2(longint'(root_floor(sq << 32)), -longint'(s.ax) * 65536),
                 -int'(tddm_pkg::PITCH_LIM), int'(tddm_pkg::PITCH_LIM));
    moved = exceeds(s.gx, held_gx, gyro_db) || exceeds(s.gy, held_gy, gyro_db) ||
            exceeds(s.gz, held_gz, gyro_db) || exceeds(roll, held_roll, tilt_db) ||
            exceeds(pitch, held_pitch, tilt_db);
    if (moved) begin
      held_gx    = s.gx;
      held_gy    = s.gy;
      held_gz    = s.gz;
      held_roll  = roll;
      held_pitch = pitch;
    end
    w.update = moved;
    w.bar_x  = bar_column(held_gx);
    w.bar_y  = bar_column(held_gy);
    w.bar_z  = bar_column(held_gz);
    w.col    = tddm_pkg::COL_W'(clip(tddm_pkg::SCREEN_WIDTH / 2 +
                                     held_roll * roll_gain / (1 << tddm_pkg::GAIN_SHIFT),
                                     0, tddm_pkg::SCREEN_WIDTH - 1));
    w.row    = tddm_pkg::ROW_W'(clip(tddm_pkg::PITCH_REF +
                                     held_pitch * pitch_gain / (1 << tddm_pkg::GAIN_SHIFT),
                                     tddm_pkg::PITCH_TOP, tddm_pkg::SCREEN_HEIGHT - 1));
    w.roll   = tddm_pkg::ROLL_W'(held_roll);
    w.pitch  = tddm_pkg::PITCH_W'(held_pitch);
    return w;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    $display("mismatch at word %0d: %s", words_checked, what);
  endtask

  task automatic check_field(string name, logic [31:0] seen, logic [31:0] due);
    if (seen !== due) note_mismatch($sformatf("%s got %0h, expected %0h", name, seen, due));
  endtask

  task automatic write_reg(logic [tddm_pkg::PADDR_W-3:0] idx,
                           logic [tddm_pkg::PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tddm_pkg::REG_GYRO_DB:    gyro_db    = int'(val[tddm_pkg::GDB_W-1:0]);
      tddm_pkg::REG_TILT_DB:    tilt_db    = int'(val[tddm_pkg::TDB_W-1:0]);
      tddm_pkg::REG_ROLL_GAIN:  roll_gain  = int'(val[tddm_pkg::GAIN_W-1:0]);
      tddm_pkg::REG_PITCH_GAIN: pitch_gain = int'(val[tddm_pkg::GAIN_W-1:0]);
      tddm_pkg::REG_BAR_HALF:   bar_half   = int'(val[tddm_pkg::BHW_W-1:0]);
      default: ;
    endcase
  endtask

  // Upper bits beyond each register width carry junk that must be dropped.
  task automatic load_settings(int gdb, int tdb, int rg, int pg, int bhw);
    write_reg(tddm_pkg::REG_GYRO_DB,
              tddm_pkg::PDATA_W'(gdb) | ($urandom() << tddm_pkg::GDB_W));
    write_reg(tddm_pkg::REG_TILT_DB,
              tddm_pkg::PDATA_W'(tdb) | ($urandom() << tddm_pkg::TDB_W));
    write_reg(tddm_pkg::REG_ROLL_GAIN,
              tddm_pkg::PDATA_W'(rg) | ($urandom() << tddm_pkg::GAIN_W));
    write_reg(tddm_pkg::REG_PITCH_GAIN,
              tddm_pkg::PDATA_W'(pg) | ($urandom() << tddm_pkg::GAIN_W));
    write_reg(tddm_pkg::REG_BAR_HALF,
              tddm_pkg::PDATA_W'(bhw) | ($urandom() << tddm_pkg::BHW_W));
  endtask

  task automatic push_sample(imu_sample_t s);
    sample_backlog.push_back(s);
    samples_queued++;
    last_sample = s;
  endtask

  task automatic wait_idle();
    while (words_checked != samples_queued) @(posedge clk);
  endtask

  function automatic logic signed [tddm_pkg::IN_W-1:0] nudge(
    logic signed [tddm_pkg::IN_W-1:0] v, int span);
    return v + tddm_pkg::IN_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [tddm_pkg::IN_W-1:0] edge_value();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sh7FFF;
    endcase
  endfunction

  // Half the samples drift around the previous one so that the deadbands are
  // straddled; the rest are random, extreme or lie on an axis.
  task automatic queue_random(int count);
    imu_sample_t s;
    int span, mode;
    repeat (count) begin
      s = last_sample;
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        span = ($urandom_range(0, 3) == 0) ? 2000 :
               ((tilt_db > 1600) ? 8000 : tilt_db * 5 + 16);
        s.ax = nudge(s.ax, span);
        s.ay = nudge(s.ay, span);
        s.az = nudge(s.az, span);
        span = gyro_db + 2;
        s.gx = nudge(s.gx, span);
        s.gy = nudge(s.gy, span);
        s.gz = nudge(s.gz, span);
      end else begin
        s.ax = tddm_pkg::IN_W'($urandom());
        s.ay = tddm_pkg::IN_W'($urandom());
        s.az = tddm_pkg::IN_W'($urandom());
        s.gx = tddm_pkg::IN_W'($urandom());
        s.gy = tddm_pkg::IN_W'($urandom());
        s.gz = tddm_pkg::IN_W'($urandom());
        if (mode == 7) begin
          s.ax = edge_value();
          s.ay = edge_value();
          s.az = edge_value();
          s.gx = edge_value();
          s.gy = edge_value();
          s.gz = edge_value();
        end else if (mode == 8) begin
          case ($urandom_range(0, 3))
            0: s.ay = '0;
            1: s.az = '0;
            2: begin
              s.ay = '0;
              s.az = '0;
            end
            default: s.ay = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
          endcase
        end else if (mode == 9) begin
          s.ax = tddm_pkg::IN_W'($urandom_range(0, 32768) - 16384);
          s.ay = tddm_pkg::IN_W'($urandom_range(0, 32768) - 16384);
          s.az = tddm_pkg::IN_W'($urandom_range(0, 32768) - 16384);
          s.gx = nudge(last_sample.gx, 300);
          s.gy = nudge(last_sample.gy, 300);
          s.gz = nudge(last_sample.gz, 300);
        end
      end
      push_sample(s);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      smp.valid   <= 1'b0;
      smp.accel_x <= '0;
      smp.accel_y <= '0;
      smp.accel_z <= '0;
      smp.gyro_x  <= '0;
      smp.gyro_y  <= '0;
      smp.gyro_z  <= '0;
      send_gap    <= 0;
    end else begin
      if (smp.valid && smp.ready) due_words.push_back(predict_display(cur_sample));
      if (!smp.valid || smp.ready) begin
        if (send_gap != 0 || sample_backlog.size() == 0) begin
          smp.valid <= 1'b0;
          if (send_gap != 0) send_gap <= send_gap - 1;
        end else begin
          cur_sample = sample_backlog.pop_front();
          smp.accel_x <= cur_sample.ax;
          smp.accel_y <= cur_sample.ay;
          smp.accel_z <= cur_sample.az;
          smp.gyro_x  <= cur_sample.gx;
          smp.gyro_y  <= cur_sample.gy;
          smp.gyro_z  <= cur_sample.gz;
          smp.valid   <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 6);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (due_words.size() == 0) begin
          note_mismatch("result word with none due");
        end else begin
          want = due_words.pop_front();
          check_field("update", res.update, want.update);
          check_field("bar_end_x", res.bar_end_x, want.bar_x);
          check_field("bar_end_y", res.bar_end_y, want.bar_y);
          check_field("bar_end_z", res.bar_end_z, want.bar_z);
          check_field("roll_marker_col", res.roll_marker_col, want.col);
          check_field("pitch_marker_row", res.pitch_marker_row, want.row);
          check_field("roll_angle", res.roll_angle, want.roll);
          check_field("pitch_angle", res.pitch_angle, want.pitch);
          words_checked++;
        end
      end
      if (recv_stall != 0) begin
        res.ready  <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res.ready  <= 1'b0;
        recv_stall <= $urandom_range(0, 5);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** tilt_deadband_display_mapper_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    last_sample = '{0, 0, 0, 0, 0, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero vector, the axes, both poles of pitch, and the seam at 180 degrees.
    push_sample('{0, 0, 0, 0, 0, 0});
    push_sample('{0, 0, -16384, 0, 0, 0});
    push_sample('{0, 0, 16384, 0, 0, 0});
    push_sample('{0, 16384, 0, 0, 0, 0});
    push_sample('{0, -16384, 0, 0, 0, 0});
    push_sample('{-32768, 0, 0, 0, 0, 0});
    push_sample('{32767, 0, 0, 0, 0, 0});
    push_sample('{0, -1, -32768, 0, 0, 0});
    push_sample('{0, 1, -32768, 0, 0, 0});
    push_sample('{0, 0, 0, 0, 0, 0});
    // Gyro changes exactly at the deadband, then just beyond it.
    push_sample('{0, 0, 0, 100, -100, 100});
    push_sample('{0, 0, 0, 101, 0, 0});
    push_sample('{0, 0, 0, 101, 0, 0});
    push_sample('{32767, 32767, 32767, 32767, -32768, -1});
    push_sample('{-32768, -32768, -32768, -32768, 32767, 0});
    push_sample('{1, 1, 1, 1, 1, 1});
    push_sample('{-1, -1, -1, -1, -1, -1});
    push_sample('{0, 16384, 16384, 0, 0, 0});
    push_sample('{0, 16390, 16384, 0, 0, 0});
    push_sample('{-16384, 0, 16384, 0, 0, 0});
    push_sample('{16384, -16384, -16384, -32768, -32768, -32768});
    wait_idle();

    load_settings(65535, 11520, 1023, 1023, 127);
    queue_random(200);
    wait_idle();

    load_settings(0, 0, 0, 0, 0);
    queue_random(150);
    wait_idle();

    for (int k = tddm_pkg::NUM_REGS; k < (1 << (tddm_pkg::PADDR_W - 2)); k++) begin
      write_reg((tddm_pkg::PADDR_W - 2)'(k), $urandom());
    end
    queue_random(50);
    wait_idle();

    repeat (4) begin
      load_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11520) : $urandom_range(0, 200),
                    $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 127));
      queue_random(250);
      wait_idle();
    end

    calm = 1'b1;
    load_settings(tddm_pkg::GDB_RST, tddm_pkg::TDB_RST, $urandom_range(0, 1023),
                  tddm_pkg::GAIN_RST, tddm_pkg::BHW_RST);
    queue_random(250);
    wait_idle();
    repeat (2 * SAMPLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** tilt_deadband_display_mapper_unit: PASSED **");
    end else begin
      $display("** tilt_deadband_display_mapper_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tddm_pkg.sv
rtl/core/tddm_if.sv
rtl/core/tilt_deadband_display_mapper_unit.sv
sim/tb_tilt_deadband_display_mapper_unit.sv
